// ===== design/wmme_pkg.sv =====
package wmme_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_BUCKETS  = 64;

  localparam int CH_W   = $clog2(MAX_CHANNELS);
  localparam int CC_W   = 4;
  localparam int BC_W   = 7;
  localparam int BI_W   = 6;
  localparam int PEAK_W = SAMPLE_BITS + 1;
  localparam int OPK_W  = 16;

  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FLD_W   = BI_W + 2 * SAMPLE_BITS + OPK_W;
  localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  localparam int TUSER_EMPTY    = 0;
  localparam int TUSER_OVERFLOW = 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT  = 2'd1;

  localparam logic [CC_W-1:0] CHANNEL_COUNT_RST = 4'd2;
  localparam logic [BC_W-1:0] BUCKET_COUNT_RST  = 7'd64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FRAMES,
    ST_STEP,
    ST_BSTART,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // Magnitude of a signed sample; the most negative code needs the extra bit.
  function automatic logic [PEAK_W-1:0] mag(input logic [SAMPLE_BITS-1:0] v);
    logic [PEAK_W-1:0] e;
    e = {v[SAMPLE_BITS-1], v};
    return v[SAMPLE_BITS-1] ? (~e + PEAK_W'(1)) : e;
  endfunction

  function automatic logic [CC_W-1:0] eff_channels(input logic [CC_W-1:0] cc);
    if (cc == '0) begin
      return CC_W'(1);
    end else if (cc > CC_W'(MAX_CHANNELS)) begin
      return CC_W'(MAX_CHANNELS);
    end
    return cc;
  endfunction

endpackage

// ===== design/waveform_min_max_envelope.sv =====
// Samples load at one word per cycle; the store write port sets that rate.
// After the word marked last: two serial divisions (samples by channels, frames by buckets),
// then per bucket one read per frame from the single store read port, plus any stall on
// the output. No new word is taken until the last result.
// Reset (synchronous, active high) sets channel_count 2, bucket_count 64 and
// clears all run state; sample store contents stay undefined until written.
module waveform_min_max_envelope #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [wmme_pkg::IN_TDATA_W-1:0]  s_tdata,   // sample_value
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // bucket_index, bucket_min, bucket_max, overall_peak, zero fill
  output logic [wmme_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast,
  output logic [wmme_pkg::OUT_TUSER_W-1:0] m_tuser,   // empty_result, store_overflow
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wmme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wmme_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wmme_pkg::*;

  localparam int SL_W  = $clog2(MAX_SAMPLES + 1);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CMP_W = (SL_W > BC_W) ? SL_W : BC_W;

  state_t state, state_next;

  logic [CC_W-1:0] channel_count;
  logic [BC_W-1:0] bucket_count;

  logic [SL_W-1:0]   samples_loaded;
  logic [CH_W-1:0]   pos;
  logic              overflow_seen;
  logic [PEAK_W-1:0] peaks [MAX_CHANNELS];

  logic [CC_W-1:0]   run_ch;
  logic [BC_W-1:0]   nb_req;
  logic [BC_W-1:0]   nb;
  logic [CC_W-1:0]   scan_c;
  logic [PEAK_W-1:0] best;
  logic [CH_W-1:0]   loud;

  logic [SL_W-1:0] q0;
  logic [BC_W-1:0] r0;
  logic [BC_W-1:0] acc_r;
  logic [SL_W-1:0] end_f;
  logic [SL_W-1:0] i_f;
  logic [SL_W-1:0] addr;
  logic [BC_W-1:0] b;
  logic            first;
  logic            rd_valid;

  logic signed [SAMPLE_BITS-1:0] mn;
  logic signed [SAMPLE_BITS-1:0] mx;
  logic signed [SAMPLE_BITS-1:0] rd_s;
  logic [PEAK_W-1:0]             running_peak;

  logic [CC_W-1:0]        ch_eff;
  logic                   in_acc;
  logic                   has_room;
  logic                   store_we;
  logic [CH_W-1:0]        pos_eff;
  logic [CC_W-1:0]        pos_inc;
  logic [CH_W-1:0]        pos_wrap;
  logic [CH_W-1:0]        peak_raddr;
  logic [PEAK_W-1:0]      peak_rd;
  logic [PEAK_W-1:0]      in_mag;
  logic [SL_W-1:0]        sl_plus;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   scan_done;

  logic            div_start;
  logic [SL_W-1:0] div_dividend;
  logic [BC_W-1:0] div_divisor;
  logic            div_busy;
  logic [SL_W-1:0] div_q;
  logic [BC_W-1:0] div_r;

  logic            empty_run;
  logic [BC_W-1:0] nb_sel;
  logic [BC_W:0]   acc_t;
  logic            acc_carry;
  logic            out_free;
  logic            rd_issue;
  logic            emit_bucket;
  logic            emit_empty;
  logic            final_b;

  logic [PEAK_W-1:0] mag_mn;
  logic [PEAK_W-1:0] mag_mx;
  logic [PEAK_W-1:0] rp_a;
  logic [PEAK_W-1:0] rp_new;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_LOAD);
  assign in_acc    = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
      bucket_count  <= BUCKET_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[CC_W-1:0];
        CFG_BUCKET_COUNT:  bucket_count  <= cfg_data[BC_W-1:0];
        default: ;
      endcase
    end
  end

  // Loading side.
  always_comb begin
    ch_eff     = eff_channels(channel_count);
    has_room   = samples_loaded < SL_W'(MAX_SAMPLES);
    store_we   = in_acc & has_room;
    pos_eff    = ({1'b0, pos} >= ch_eff) ? '0 : pos;
    pos_inc    = CC_W'(pos_eff) + CC_W'(1);
    pos_wrap   = (pos_inc >= ch_eff) ? '0 : pos_inc[CH_W-1:0];
    peak_raddr = (state == ST_LOAD) ? pos_eff : scan_c[CH_W-1:0];
    peak_rd    = peaks[peak_raddr];
    in_mag     = mag(s_tdata[SAMPLE_BITS-1:0]);
    sl_plus    = samples_loaded + SL_W'(store_we);
    scan_done  = scan_c >= run_ch;
    rd_s       = signed'(rd_data);
  end

  wmme_store #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (samples_loaded[AW-1:0]),
    .wdata (s_tdata[SAMPLE_BITS-1:0]),
    .raddr (addr[AW-1:0]),
    .rdata (rd_data)
  );

  wmme_div #(
    .NW (SL_W),
    .DW (BC_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Bucket boundary stepping and result values.
  always_comb begin
    empty_run = (nb_req == '0) || (div_q == '0);
    nb_sel    = (CMP_W'(nb_req) > CMP_W'(div_q)) ? BC_W'(div_q) : nb_req;
    acc_t     = {1'b0, acc_r} + {1'b0, r0};
    acc_carry = acc_t >= {1'b0, nb};
    mag_mn    = mag(mn);
    mag_mx    = mag(mx);
    rp_a      = (mag_mn > running_peak) ? mag_mn : running_peak;
    rp_new    = (mag_mx > rp_a) ? mag_mx : rp_a;
    final_b   = (b + BC_W'(1)) == nb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = sl_plus;
    div_divisor  = BC_W'(ch_eff);
    rd_issue     = 1'b0;
    emit_bucket  = 1'b0;
    emit_empty   = 1'b0;
    case (state)
      ST_LOAD: begin
        if (in_acc && s_tlast) begin
          div_start  = 1'b1;
          state_next = ST_FRAMES;
        end
      end
      ST_FRAMES: begin
        div_dividend = div_q;
        div_divisor  = nb_sel;
        if (!div_busy && scan_done) begin
          if (empty_run) begin
            state_next = ST_EMPTY;
          end else begin
            div_start  = 1'b1;
            state_next = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (!div_busy) begin
          state_next = ST_BSTART;
        end
      end
      ST_BSTART: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        rd_issue = 1'b1;
        if ((i_f + SL_W'(1)) == end_f) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_bucket = 1'b1;
          state_next  = final_b ? ST_LOAD : ST_BSTART;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          emit_empty = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Run state: cleared on reset and once the last result of a run is loaded.
  always_ff @(posedge clk) begin
    if (rst || emit_empty || (emit_bucket && final_b)) begin
      samples_loaded <= '0;
      pos            <= '0;
      overflow_seen  <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        peaks[c] <= '0;
      end
    end else if (in_acc) begin
      if (has_room) begin
        samples_loaded <= sl_plus;
        pos            <= pos_wrap;
        if (in_mag > peak_rd) begin
          peaks[pos_eff] <= in_mag;
        end
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tlast) begin
      run_ch <= ch_eff;
      nb_req <= (bucket_count > BC_W'(MAX_BUCKETS)) ? BC_W'(MAX_BUCKETS) : bucket_count;
      scan_c <= '0;
    end
    // Loudest channel: first strictly larger peak wins, so ties keep the lower index.
    if (state == ST_FRAMES && !scan_done) begin
      scan_c <= scan_c + CC_W'(1);
      if (scan_c == '0 || peak_rd > best) begin
        best <= peak_rd;
        loud <= scan_c[CH_W-1:0];
      end
    end
    if (state == ST_FRAMES && state_next == ST_STEP) begin
      nb <= nb_sel;
    end
    if (state == ST_STEP && !div_busy) begin
      q0           <= div_q;
      r0           <= div_r;
      acc_r        <= '0;
      end_f        <= '0;
      b            <= '0;
      addr         <= SL_W'(loud);
      running_peak <= '0;
    end
    // End of the next bucket is the previous end plus F/B, with the remainder
    // carried in a running sum that stays below twice B.
    if (state == ST_BSTART) begin
      acc_r <= acc_carry ? BC_W'(acc_t - {1'b0, nb}) : acc_t[BC_W-1:0];
      end_f <= end_f + q0 + SL_W'(acc_carry);
      i_f   <= end_f;
      first <= 1'b1;
    end
    if (rd_issue) begin
      i_f  <= i_f + SL_W'(1);
      addr <= addr + SL_W'(run_ch);
    end
    if (rd_valid) begin
      first <= 1'b0;
      if (first || rd_s < mn) begin
        mn <= rd_s;
      end
      if (first || rd_s > mx) begin
        mx <= rd_s;
      end
    end
    if (emit_bucket) begin
      running_peak <= rp_new;
      b            <= b + BC_W'(1);
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_bucket || emit_empty) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_bucket) begin
      m_tdata <= OUT_TDATA_W'({(final_b ? rp_new[OPK_W-1:0] : OPK_W'(0)),
                               mx, mn, b[BI_W-1:0]});
      m_tlast <= final_b;
      m_tuser[TUSER_EMPTY]    <= 1'b0;
      m_tuser[TUSER_OVERFLOW] <= overflow_seen;
    end else if (emit_empty) begin
      m_tdata <= '0;
      m_tlast <= 1'b1;
      m_tuser[TUSER_EMPTY]    <= 1'b1;
      m_tuser[TUSER_OVERFLOW] <= overflow_seen;
    end
  end

endmodule

// ===== design/wmme_store.sv =====
module wmme_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [wmme_pkg::SAMPLE_BITS-1:0] wdata,
  input  logic [AW-1:0]                    raddr,
  output logic [wmme_pkg::SAMPLE_BITS-1:0] rdata
);
  import wmme_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/wmme_div.sv =====
module wmme_div #(
  parameter int NW = 13,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);
  import wmme_pkg::*;

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_diff;
  logic             take;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh   = {rem, quo[NW-1]};
    take     = rem_sh >= {1'b0, dvs};
    rem_diff = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NW);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[NW-2:0], take};
      rem <= take ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== verif/envelope_checker.sv =====
module envelope_checker #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [wmme_pkg::IN_TDATA_W-1:0]  s_tdata,   // sample_value
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  // bucket_index, bucket_min, bucket_max, overall_peak, zero fill
  input  logic [wmme_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             m_tlast,
  input  logic [wmme_pkg::OUT_TUSER_W-1:0] m_tuser,   // empty_result, store_overflow
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [wmme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wmme_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                      errors,
  output int unsigned                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import wmme_pkg::*;

  typedef struct packed {
    logic [BI_W-1:0]        index;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [OPK_W-1:0]       peak;
    logic                   fin;
    logic                   empty;
    logic                   ovf;
  } bucket_t;

  logic [CC_W-1:0]               channel_count;
  logic [BC_W-1:0]               bucket_count;
  logic signed [SAMPLE_BITS-1:0] sample_mem [STORE_DEPTH];
  int                            ch_peak [MAX_CHANNELS];
  int                            loaded;
  int                            chan_pos;
  logic                          dropped;
  bucket_t                       expected_buckets [$];
  int unsigned                   mismatches;

  function automatic int abs_q15(logic signed [SAMPLE_BITS-1:0] v);
    int x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  task automatic start_new_buffer();
    foreach (ch_peak[c]) ch_peak[c] = 0;
    loaded = 0;
    chan_pos = 0;
    dropped = 1'b0;
  endtask

  // Stores one sample and, on the marked one, works out every bucket of the buffer.
  task automatic take_sample(logic signed [SAMPLE_BITS-1:0] v, logic last);
    int ch;
    int frames;
    int nb;
    int loud;
    int lo_f;
    int hi_f;
    int pos;
    int top_mag;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic signed [SAMPLE_BITS-1:0] s;
    bucket_t r;
    ch = (channel_count == 0) ? 1 :
         (channel_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(channel_count);
    if (loaded < STORE_DEPTH) begin
      pos = (chan_pos >= ch) ? 0 : chan_pos;
      sample_mem[loaded] = v;
      loaded++;
      if (abs_q15(v) > ch_peak[pos]) ch_peak[pos] = abs_q15(v);
      chan_pos = (pos + 1 >= ch) ? 0 : pos + 1;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;

    frames = loaded / ch;
    nb = (bucket_count > MAX_BUCKETS) ? MAX_BUCKETS : int'(bucket_count);
    if (nb == 0 || frames == 0) begin
      r = '0;
      r.fin = 1'b1;
      r.empty = 1'b1;
      r.ovf = dropped;
      expected_buckets.push_back(r);
    end else begin
      if (nb > frames) nb = frames;
      // Ties go to the lowest channel; a partial trailing frame still counts here.
      loud = 0;
      for (int c = 1; c < ch; c++) begin
        if (ch_peak[c] > ch_peak[loud]) loud = c;
      end
      top_mag = 0;
      for (int b = 0; b < nb; b++) begin
        lo_f = b * frames / nb;
        hi_f = (b + 1) * frames / nb;
        if (hi_f <= lo_f) hi_f = lo_f + 1;
        if (hi_f > frames) hi_f = frames;
        lo = sample_mem[lo_f * ch + loud];
        hi = lo;
        for (int i = lo_f; i < hi_f; i++) begin
          s = sample_mem[i * ch + loud];
          if (s < lo) lo = s;
          if (s > hi) hi = s;
        end
        if (abs_q15(lo) > top_mag) top_mag = abs_q15(lo);
        if (abs_q15(hi) > top_mag) top_mag = abs_q15(hi);
        r.index = BI_W'(b);
        r.lo = lo;
        r.hi = hi;
        r.fin = (b == nb - 1);
        r.peak = r.fin ? OPK_W'(top_mag) : '0;
        r.empty = 1'b0;
        r.ovf = dropped;
        expected_buckets.push_back(r);
      end
    end
    start_new_buffer();
  endtask

  always @(posedge clk) begin : monitor
    bucket_t got;
    bucket_t want;
    if (rst) begin
      channel_count = CHANNEL_COUNT_RST;
      bucket_count = BUCKET_COUNT_RST;
      start_new_buffer();
      expected_buckets.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.index = m_tdata[BI_W-1:0];
        got.lo = m_tdata[BI_W +: SAMPLE_BITS];
        got.hi = m_tdata[BI_W + SAMPLE_BITS +: SAMPLE_BITS];
        got.peak = m_tdata[BI_W + 2 * SAMPLE_BITS +: OPK_W];
        got.fin = m_tlast;
        got.empty = m_tuser[TUSER_EMPTY];
        got.ovf = m_tuser[TUSER_OVERFLOW];
        if (expected_buckets.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected bucket word: idx %0d min %0d max %0d peak %0d",
                     got.index, $signed(got.lo), $signed(got.hi), got.peak);
          end
          mismatches++;
        end else begin
          want = expected_buckets.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("bucket mismatch: expected idx %0d min %0d max %0d peak %0d %b%b%b",
                       want.index, $signed(want.lo), $signed(want.hi), want.peak,
                       want.fin, want.empty, want.ovf);
              $display("                 actual   idx %0d min %0d max %0d peak %0d %b%b%b",
                       got.index, $signed(got.lo), $signed(got.hi), got.peak,
                       got.fin, got.empty, got.ovf);
            end
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CHANNEL_COUNT) channel_count = cfg_data[CC_W-1:0];
        else if (cfg_index == CFG_BUCKET_COUNT) bucket_count = cfg_data[BC_W-1:0];
      end
      if (s_tvalid && s_tready) take_sample(s_tdata[SAMPLE_BITS-1:0], s_tlast);
    end
    errors <= mismatches;
    pending <= expected_buckets.size();
  end

endmodule

// ===== verif/waveform_min_max_envelope_test.sv =====
module waveform_min_max_envelope_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wmme_pkg::*;

  localparam int STORE_DEPTH = 4096;
  // A one-bucket pass over a full store is the longest quiet stretch.
  localparam int STALL_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 280;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;        // sample_value
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // bucket_index, bucket_min, bucket_max, overall_peak, zero fill
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic [OUT_TUSER_W-1:0] m_tuser;             // empty_result, store_overflow
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int unsigned            errors;
  int unsigned            pending;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 75;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  waveform_min_max_envelope #(.MAX_SAMPLES(STORE_DEPTH)) uut (.*);

  envelope_checker #(.STORE_DEPTH(STORE_DEPTH)) checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL waveform_min_max_envelope");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(9))
      0: begin
        return 16'h8000;
      end
      1: begin
        return 16'h7FFF;
      end
      2: begin
        return 16'h0000;
      end
      default: begin
        return SAMPLE_BITS'($urandom);
      end
    endcase
  endfunction

  // Valid stays high from one word to the next unless the sender takes a gap.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] v, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_buffer(int count);
    for (int k = 0; k < count; k++) send_sample(random_sample(), k == count - 1);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes on both channels, equal peaks, and a partial trailing frame.
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    // Fewer samples than one frame.
    send_sample(16'h1234, 1'b1);

    drain_results();
    write_reg(CFG_CHANNEL_COUNT, 7'd0);
    write_reg(CFG_BUCKET_COUNT, 7'd0);
    send_buffer(3);

    drain_results();
    write_reg(CFG_CHANNEL_COUNT, 7'd15);
    write_reg(CFG_BUCKET_COUNT, 7'd127);
    send_buffer(8);

    // Channel count changes halfway through a buffer.
    drain_results();
    write_reg(CFG_CHANNEL_COUNT, 7'd3);
    write_reg(CFG_BUCKET_COUNT, 7'd2);
    send_sample(random_sample(), 1'b0);
    send_sample(random_sample(), 1'b0);
    send_sample(random_sample(), 1'b0);
    drain_results();
    write_reg(CFG_CHANNEL_COUNT, 7'd2);
    send_buffer(4);

    drain_results();
    write_reg(CFG_CHANNEL_COUNT, 7'd1);
    write_reg(CFG_BUCKET_COUNT, 7'd1);
    send_buffer(3);

    r = items_sent + RANDOM_ITEMS;
    while (items_sent < r) begin
      if (items_sent + RANDOM_ITEMS * 2 / 3 < r) begin
        send_idle_pct = 35;
        recv_idle_pct <= 75;
      end else if (items_sent + RANDOM_ITEMS / 3 < r) begin
        send_idle_pct = 75;
        recv_idle_pct <= 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if ($urandom_range(99) < 40) begin
        drain_results();
        write_reg(CFG_CHANNEL_COUNT, ($urandom_range(99) < 80) ?
                  CFG_DATA_W'($urandom_range(1, 8)) : CFG_DATA_W'($urandom_range(0, 15)));
        case ($urandom_range(3))
          0: begin
            write_reg(CFG_BUCKET_COUNT, CFG_DATA_W'($urandom_range(0, 127)));
          end
          1: begin
            write_reg(CFG_BUCKET_COUNT, CFG_DATA_W'($urandom_range(13, 64)));
          end
          default: begin
            write_reg(CFG_BUCKET_COUNT, CFG_DATA_W'($urandom_range(1, 12)));
          end
        endcase
      end
      send_buffer($urandom_range(1, 40));
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS waveform_min_max_envelope");
    end else begin
      $display("FAIL waveform_min_max_envelope");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wmme_pkg.sv
design/wmme_store.sv
design/wmme_div.sv
design/waveform_min_max_envelope.sv
verif/envelope_checker.sv
verif/waveform_min_max_envelope_test.sv
